// ----- hdl/top_k_merge_sorted_lists_defines.svh -----
// Assertion macros shared by the top-level merge block.
`ifndef TOP_K_MERGE_SORTED_LISTS_DEFINES_SVH
`define TOP_K_MERGE_SORTED_LISTS_DEFINES_SVH
`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define TKM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next cycle.
`define TKM_ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);
`else
`define TKM_ASSERT(label, clk, rst, prop, msg)
`define TKM_ASSERT_NEXT(label, clk, rst, cond, nxt, msg)
`endif
`endif

// ----- hdl/tkm_pkg.sv -----
// Types and constants shared by the merge controller, datapath and top level.
`timescale 1ns / 1ps
package tkm_pkg;

   localparam int MAX_RESULTS = 16;

   localparam logic [1:0] CSR_ACTIVE_PARTS = 2'd0;
   localparam logic [1:0] CSR_RESULT_COUNT = 2'd1;
   localparam logic [1:0] CSR_SHARDS_PER_PART = 2'd2;
   localparam logic [1:0] CSR_SHARD_SIZE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_READ,
      ST_CMP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_we;
      logic merge_init;
      logic scan_start;
      logic scan_rd;
      logic scan_cmp;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic want_zero;
      logic last_ptr;
      logic last_result;
   } ctl_sts_type;

endpackage

// ----- hdl/top_k_merge_sorted_lists.sv -----
// Top level of the k-way merge that returns the smallest distances of one query.
`timescale 1ns / 1ps
`include "top_k_merge_sorted_lists_defines.svh"
// Load candidates with start while busy is low: each transaction writes one
// (key, distance) entry at list req_part, rank req_slot, one per clock cycle.
// The transaction with req_load_done high is stored too and then starts the
// merge; busy stays high until the merge is over. The merge has a setup step,
// then for each result it walks the partition heads through the single read
// port of the candidate store, a read and a compare step per head, and then
// emits the pick. Results leave in the cycle after they are picked, each as a
// one-cycle rsp_valid strobe; the receiver cannot stall, so capture every
// strobe. The last result of a query carries rsp_out_last, and a result
// count of zero gives no transaction at all. Write the csr_ registers only
// while the block is idle.
module top_k_merge_sorted_lists #(
   parameter int PARTITIONS = 8,
   parameter int LIST_LEN   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_part,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_cand_key,
   input  logic [31:0] req_cand_dist,
   input  logic        req_load_done,
   output logic        rsp_valid,
   output logic [31:0] rsp_merged_id,
   output logic [31:0] rsp_merged_dist,
   output logic [3:0]  rsp_out_rank,
   output logic        rsp_out_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   tkm_pkg::ctl_cmd_type cmd;
   tkm_pkg::ctl_sts_type sts;

   // sequence the load, scan and emit steps
   tkm_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_load_done (req_load_done),
      .sts           (sts),
      .cmd           (cmd),
      .busy          (busy)
   );

   // hold the lists, search the heads and register each result
   tkm_datapath #(
      .PARTITIONS (PARTITIONS),
      .LIST_LEN   (LIST_LEN)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_part        (req_part),
      .req_slot        (req_slot),
      .req_cand_key    (req_cand_key),
      .req_cand_dist   (req_cand_dist),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_merged_id   (rsp_merged_id),
      .rsp_merged_dist (rsp_merged_dist),
      .rsp_out_rank    (rsp_out_rank),
      .rsp_out_last    (rsp_out_last)
   );

   // results are always separated by at least a read, compare and pick cycle
   `TKM_ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_valid, !rsp_valid, "back-to-back result strobes")
   // only the final result of a query may appear once the block is idle again
   `TKM_ASSERT(a_idle_only_last, clock, reset, !rsp_valid || busy || rsp_out_last, "non-final result while idle")
   // a final candidate must start the merge
   `TKM_ASSERT_NEXT(a_merge_starts, clock, reset, start && !busy && req_load_done, busy, "merge did not start")
   // the store is never written while a merge is running
   `TKM_ASSERT(a_no_load_in_merge, clock, reset, !(cmd.load_we && busy), "candidate write during merge")

endmodule

// ----- hdl/tkm_controller.sv -----
// Sequencer for candidate loading and the head-by-head merge scan.
`timescale 1ns / 1ps
module tkm_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_load_done,
   input  tkm_pkg::ctl_sts_type sts,
   output tkm_pkg::ctl_cmd_type cmd,
   output logic                busy
);

   tkm_pkg::state_type state_ff;
   tkm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tkm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tkm_pkg::ST_IDLE: begin
            if (start && req_load_done) state_in = tkm_pkg::ST_INIT;
         end
         tkm_pkg::ST_INIT: begin
            state_in = sts.want_zero ? tkm_pkg::ST_IDLE : tkm_pkg::ST_READ;
         end
         tkm_pkg::ST_READ: begin
            state_in = tkm_pkg::ST_CMP;
         end
         tkm_pkg::ST_CMP: begin
            state_in = sts.last_ptr ? tkm_pkg::ST_EMIT : tkm_pkg::ST_READ;
         end
         tkm_pkg::ST_EMIT: begin
            state_in = sts.last_result ? tkm_pkg::ST_IDLE : tkm_pkg::ST_READ;
         end
         default: begin
            state_in = tkm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         tkm_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.load_we = start;
         end
         tkm_pkg::ST_INIT: begin
            cmd.merge_init = 1'b1;
            cmd.scan_start = 1'b1;
         end
         tkm_pkg::ST_READ: begin
            cmd.scan_rd = 1'b1;
         end
         tkm_pkg::ST_CMP: begin
            cmd.scan_cmp = 1'b1;
         end
         tkm_pkg::ST_EMIT: begin
            cmd.emit       = 1'b1;
            cmd.scan_start = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ----- hdl/tkm_datapath.sv -----
// Candidate store, head pointers, minimum search and result registers.
`timescale 1ns / 1ps
module tkm_datapath #(
   parameter int PARTITIONS = 8,
   parameter int LIST_LEN   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tkm_pkg::ctl_cmd_type cmd,
   output tkm_pkg::ctl_sts_type sts,
   input  logic [2:0]           req_part,
   input  logic [3:0]           req_slot,
   input  logic [31:0]          req_cand_key,
   input  logic [31:0]          req_cand_dist,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   output logic                 rsp_valid,
   output logic [31:0]          rsp_merged_id,
   output logic [31:0]          rsp_merged_dist,
   output logic [3:0]           rsp_out_rank,
   output logic                 rsp_out_last
);

   localparam int PW    = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
   localparam int SW    = (LIST_LEN > 1) ? $clog2(LIST_LEN) : 1;
   localparam int HW    = $clog2(LIST_LEN + 1);
   localparam int AW    = PW + SW;
   localparam int DEPTH = 1 << AW;

   // configuration
   logic [3:0]  cfg_active_ff;
   logic [4:0]  cfg_count_ff;
   logic [15:0] cfg_spp_ff;
   logic [31:0] cfg_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_active_ff <= 4'd1;
         cfg_count_ff  <= 5'd16;
         cfg_spp_ff    <= 16'd1;
         cfg_size_ff   <= 32'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            tkm_pkg::CSR_ACTIVE_PARTS:    cfg_active_ff <= csr_wdata[3:0];
            tkm_pkg::CSR_RESULT_COUNT:    cfg_count_ff  <= csr_wdata[4:0];
            tkm_pkg::CSR_SHARDS_PER_PART: cfg_spp_ff    <= csr_wdata[15:0];
            tkm_pkg::CSR_SHARD_SIZE:      cfg_size_ff   <= csr_wdata;
         endcase
      end
   end

   logic [4:0]  num_parts;
   logic [4:0]  want;
   logic [10:0] total_entries;

   always_comb begin
      if (cfg_active_ff == 4'd0) begin
         num_parts = 5'd1;
      end else if ({1'b0, cfg_active_ff} > 5'(PARTITIONS)) begin
         num_parts = 5'(PARTITIONS);
      end else begin
         num_parts = {1'b0, cfg_active_ff};
      end
      if (cfg_count_ff > 5'(tkm_pkg::MAX_RESULTS)) begin
         want = 5'(tkm_pkg::MAX_RESULTS);
      end else begin
         want = cfg_count_ff;
      end
   end

   assign total_entries = 11'(num_parts) * 11'(LIST_LEN);

   // candidate store
   logic [63:0]   store_mem [DEPTH];
   logic [63:0]   rd_data_ff;
   logic [3:0]    part_ext;
   logic [5:0]    slot_ext;
   logic          wr_in_range;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   assign part_ext    = {1'b0, req_part};
   assign slot_ext    = {2'b00, req_slot};
   assign wr_in_range = ({2'b00, req_part} < 5'(PARTITIONS)) &&
                        ({3'b000, req_slot} < 7'(LIST_LEN));
   assign wr_addr     = {part_ext[PW-1:0], slot_ext[SW-1:0]};

   logic [PW-1:0] ptr_ff;
   logic [HW-1:0] head_ff [PARTITIONS];
   logic [HW-1:0] head_cur;

   assign head_cur = head_ff[ptr_ff];
   assign rd_addr  = {ptr_ff, head_cur[SW-1:0]};

   always_ff @(posedge clock) begin
      if (cmd.load_we && wr_in_range) begin
         store_mem[wr_addr] <= {req_cand_key, req_cand_dist};
      end
      if (cmd.scan_rd) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // head pointers and merge counters
   logic [4:0]  emitted_ff;
   logic [4:0]  emitted_next;
   logic [31:0] pitch_ff;
   logic [47:0] pitch_full;

   assign pitch_full   = {32'd0, cfg_spp_ff} * {16'd0, cfg_size_ff};
   assign emitted_next = emitted_ff + 5'd1;

   logic [PW-1:0] best_p_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.merge_init) begin
         for (int p = 0; p < PARTITIONS; p++) begin
            head_ff[p] <= '0;
         end
      end else if (cmd.emit) begin
         head_ff[best_p_ff] <= head_ff[best_p_ff] + HW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.merge_init) begin
         emitted_ff <= 5'd0;
      end else if (cmd.emit) begin
         emitted_ff <= emitted_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.merge_init) begin
         pitch_ff <= pitch_full[31:0];
      end
   end

   // minimum search over the heads
   logic        elig_ff;
   logic        found_ff;
   logic [31:0] base_acc_ff;
   logic [31:0] best_dist_ff;
   logic [31:0] best_key_ff;
   logic [31:0] best_base_ff;
   logic        take;

   assign take = elig_ff && (!found_ff || (rd_data_ff[31:0] < best_dist_ff));

   always_ff @(posedge clock) begin
      if (reset || cmd.scan_start) begin
         ptr_ff      <= '0;
         found_ff    <= 1'b0;
         base_acc_ff <= 32'd0;
      end else if (cmd.scan_cmp) begin
         ptr_ff      <= ptr_ff + PW'(1);
         base_acc_ff <= base_acc_ff + pitch_ff;
         if (take) found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         elig_ff <= (head_cur < HW'(LIST_LEN));
      end
      if (cmd.scan_cmp && take) begin
         best_p_ff    <= ptr_ff;
         best_dist_ff <= rd_data_ff[31:0];
         best_key_ff  <= rd_data_ff[63:32];
         best_base_ff <= base_acc_ff;
      end
   end

   assign sts.want_zero   = (want == 5'd0);
   assign sts.last_ptr    = (5'(ptr_ff) == (num_parts - 5'd1));
   assign sts.last_result = (emitted_next == want) || (11'(emitted_next) == total_entries);

   // result registers
   logic        rsp_valid_ff;
   logic [31:0] rsp_id_ff;
   logic [31:0] rsp_dist_ff;
   logic [3:0]  rsp_rank_ff;
   logic        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_id_ff   <= best_base_ff + best_key_ff;
         rsp_dist_ff <= best_dist_ff;
         rsp_rank_ff <= emitted_ff[3:0];
         rsp_last_ff <= sts.last_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_merged_id   = rsp_id_ff;
   assign rsp_merged_dist = rsp_dist_ff;
   assign rsp_out_rank    = rsp_rank_ff;
   assign rsp_out_last    = rsp_last_ff;

endmodule
